/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/gbtf_pkg.sv */
// ----------------------------------------------------------------------------
// gbtf_pkg
// Shared types and character codes for the binary/text frame parser.
// ----------------------------------------------------------------------------
package gbtf_pkg;

  localparam logic [7:0] SYNC_ONE   = 8'hB5;
  localparam logic [7:0] SYNC_TWO   = 8'h62;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  localparam logic [5:0] HDR_SAT    = 6'd63;
  localparam logic [5:0] HDR_MIN    = 6'd5;

  localparam logic KIND_BINARY = 1'b0;
  localparam logic KIND_TEXT   = 1'b1;

  // header byte positions inside a binary frame
  localparam logic [2:0] HIDX_SYNC2 = 3'd0;
  localparam logic [2:0] HIDX_CLASS = 3'd1;
  localparam logic [2:0] HIDX_ID    = 3'd2;
  localparam logic [2:0] HIDX_LENLO = 3'd3;
  localparam logic [2:0] HIDX_LENHI = 3'd4;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_HEAD  = 3'd1,
    MODE_BODY  = 3'd2,
    MODE_CHECK = 3'd3,
    MODE_TEXT  = 3'd4
  } mode_t;

  typedef struct packed {
    logic        frame_kind;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic        checksum_ok;
    logic        star_seen;
    logic        header_ok;
    logic [15:0] talker_chars;
    logic [23:0] type_chars;
    logic [5:0]  header_length;
  } result_t;

endpackage

/* hdl/gbtf_byte_if.sv */
// ----------------------------------------------------------------------------
// gbtf_byte_if / gbtf_frame_if
// Valid/ready channels for received bytes and finished frame reports.
// ----------------------------------------------------------------------------
interface gbtf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbtf_frame_if;
  logic        valid;
  logic        ready;
  logic        frame_kind;
  logic [7:0]  frame_class;
  logic [7:0]  frame_id;
  logic [15:0] frame_length;
  logic        checksum_ok;
  logic        star_seen;
  logic        header_ok;
  logic [15:0] talker_chars;
  logic [23:0] type_chars;
  logic [5:0]  header_length;

  modport source (output valid, output frame_kind, output frame_class, output frame_id,
                  output frame_length, output checksum_ok, output star_seen,
                  output header_ok, output talker_chars, output type_chars,
                  output header_length, input ready);
  modport sink   (input valid, input frame_kind, input frame_class, input frame_id,
                  input frame_length, input checksum_ok, input star_seen,
                  input header_ok, input talker_chars, input type_chars,
                  input header_length, output ready);
endinterface

/* hdl/gbtf_parser.sv */
// ----------------------------------------------------------------------------
// gbtf_parser
// Framing state and checksum registers; one byte per step.
// ----------------------------------------------------------------------------
module gbtf_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic [7:0]        rx_byte_i,
  output logic              res_vld_o,
  output gbtf_pkg::result_t res_o
);

  gbtf_pkg::mode_t mode_r, mode_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pcnt_r, pcnt_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  chk1_r, chk1_nxt;
  logic        star_r, star_nxt;
  logic        comma_r, comma_nxt;
  logic [5:0]  hcnt_r, hcnt_nxt;
  logic [15:0] talker_r, talker_nxt;
  logic [23:0] type_r, type_nxt;

  logic [7:0]  b;
  logic [7:0]  a_add, b_add;
  logic [15:0] pcnt_inc;
  logic [15:0] len_full;
  logic        hdr_ok;

  assign b        = rx_byte_i;
  assign a_add    = sum_a_r + b;
  assign b_add    = sum_b_r + a_add;
  assign pcnt_inc = pcnt_r + 16'd1;
  assign len_full = {b, len_r[7:0]};
  assign hdr_ok   = comma_r && (hcnt_r >= gbtf_pkg::HDR_MIN);

  always_comb begin
    mode_nxt   = mode_r;
    hidx_nxt   = hidx_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    pcnt_nxt   = pcnt_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    chk1_nxt   = chk1_r;
    star_nxt   = star_r;
    comma_nxt  = comma_r;
    hcnt_nxt   = hcnt_r;
    talker_nxt = talker_r;
    type_nxt   = type_r;
    res_vld_o  = 1'b0;
    res_o      = '0;

    unique case (mode_r)
      gbtf_pkg::MODE_HEAD: begin
        unique case (hidx_r)
          gbtf_pkg::HIDX_SYNC2: begin
            if (b != gbtf_pkg::SYNC_TWO) begin
              mode_nxt = gbtf_pkg::MODE_IDLE;
              if (b == gbtf_pkg::CH_DOLLAR) begin
                mode_nxt   = gbtf_pkg::MODE_TEXT;
                star_nxt   = 1'b0;
                comma_nxt  = 1'b0;
                hcnt_nxt   = '0;
                talker_nxt = '0;
                type_nxt   = '0;
              end
            end else begin
              sum_a_nxt = '0;
              sum_b_nxt = '0;
              hidx_nxt  = gbtf_pkg::HIDX_CLASS;
            end
          end
          gbtf_pkg::HIDX_CLASS: begin
            class_nxt = b;
            sum_a_nxt = a_add;
            sum_b_nxt = b_add;
            hidx_nxt  = gbtf_pkg::HIDX_ID;
          end
          gbtf_pkg::HIDX_ID: begin
            id_nxt    = b;
            sum_a_nxt = a_add;
            sum_b_nxt = b_add;
            hidx_nxt  = gbtf_pkg::HIDX_LENLO;
          end
          gbtf_pkg::HIDX_LENLO: begin
            len_nxt   = {8'd0, b};
            sum_a_nxt = a_add;
            sum_b_nxt = b_add;
            hidx_nxt  = gbtf_pkg::HIDX_LENHI;
          end
          default: begin
            // high length byte
            len_nxt   = len_full;
            sum_a_nxt = a_add;
            sum_b_nxt = b_add;
            hidx_nxt  = gbtf_pkg::HIDX_SYNC2;
            pcnt_nxt  = '0;
            mode_nxt  = (len_full == 16'd0) ? gbtf_pkg::MODE_CHECK : gbtf_pkg::MODE_BODY;
          end
        endcase
      end
      gbtf_pkg::MODE_BODY: begin
        sum_a_nxt = a_add;
        sum_b_nxt = b_add;
        pcnt_nxt  = pcnt_inc;
        if (pcnt_inc >= len_r) begin
          pcnt_nxt = '0;
          mode_nxt = gbtf_pkg::MODE_CHECK;
        end
      end
      gbtf_pkg::MODE_CHECK: begin
        if (pcnt_r == 16'd0) begin
          chk1_nxt = b;
          pcnt_nxt = 16'd1;
        end else begin
          pcnt_nxt          = '0;
          mode_nxt          = gbtf_pkg::MODE_IDLE;
          res_vld_o         = 1'b1;
          res_o.frame_kind  = gbtf_pkg::KIND_BINARY;
          res_o.frame_class = class_r;
          res_o.frame_id    = id_r;
          res_o.frame_length = len_r;
          res_o.checksum_ok = (chk1_r == sum_a_r) && (b == sum_b_r);
        end
      end
      gbtf_pkg::MODE_TEXT: begin
        if (b == gbtf_pkg::CH_DOLLAR) begin
          // sentence restarts with an empty header
          star_nxt   = 1'b0;
          comma_nxt  = 1'b0;
          hcnt_nxt   = '0;
          talker_nxt = '0;
          type_nxt   = '0;
        end else if (b == gbtf_pkg::CH_NEWLINE) begin
          mode_nxt            = gbtf_pkg::MODE_IDLE;
          res_vld_o           = 1'b1;
          res_o.frame_kind    = gbtf_pkg::KIND_TEXT;
          res_o.star_seen     = star_r;
          res_o.header_ok     = hdr_ok;
          res_o.talker_chars  = hdr_ok ? talker_r : 16'd0;
          res_o.type_chars    = hdr_ok ? type_r : 24'd0;
          res_o.header_length = hcnt_r;
        end else begin
          if (b == gbtf_pkg::CH_STAR) begin
            star_nxt = 1'b1;
          end
          if (!comma_r) begin
            if (b == gbtf_pkg::CH_COMMA) begin
              comma_nxt = 1'b1;
            end else begin
              if (hcnt_r < 6'd2) begin
                talker_nxt = {talker_r[7:0], b};
              end else if (hcnt_r < gbtf_pkg::HDR_MIN) begin
                type_nxt = {type_r[15:0], b};
              end
              if (hcnt_r < gbtf_pkg::HDR_SAT) begin
                hcnt_nxt = hcnt_r + 6'd1;
              end
            end
          end
        end
      end
      default: begin
        // idle, and any unused mode code
        mode_nxt = gbtf_pkg::MODE_IDLE;
        if (b == gbtf_pkg::SYNC_ONE) begin
          mode_nxt = gbtf_pkg::MODE_HEAD;
          hidx_nxt = gbtf_pkg::HIDX_SYNC2;
        end else if (b == gbtf_pkg::CH_DOLLAR) begin
          mode_nxt   = gbtf_pkg::MODE_TEXT;
          star_nxt   = 1'b0;
          comma_nxt  = 1'b0;
          hcnt_nxt   = '0;
          talker_nxt = '0;
          type_nxt   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= gbtf_pkg::MODE_IDLE;
      hidx_r   <= '0;
      class_r  <= '0;
      id_r     <= '0;
      len_r    <= '0;
      pcnt_r   <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      chk1_r   <= '0;
      star_r   <= 1'b0;
      comma_r  <= 1'b0;
      hcnt_r   <= '0;
      talker_r <= '0;
      type_r   <= '0;
    end else if (step_i) begin
      mode_r   <= mode_nxt;
      hidx_r   <= hidx_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      len_r    <= len_nxt;
      pcnt_r   <= pcnt_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      chk1_r   <= chk1_nxt;
      star_r   <= star_nxt;
      comma_r  <= comma_nxt;
      hcnt_r   <= hcnt_nxt;
      talker_r <= talker_nxt;
      type_r   <= type_nxt;
    end
  end

endmodule

/* hdl/gnss_binary_text_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// gnss_binary_text_frame_parser_top
// Frames a mixed binary/text byte stream and reports each finished frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_  : one received byte per request (valid/ready). Binary frames open
//          with B5 62, text sentences with '$' and close at newline.
//   out_ : one request per finished frame or sentence. frame_kind tells
//          binary (class, id, length, checksum_ok) from text (star_seen,
//          header_ok, talker/type chars, header_length); the other group
//          reads zero.
//   Throughput: one byte per cycle, sustained, as long as out_ takes each
//   report when offered (the input register and the report register form
//   two stages). A report left waiting on out_ holds the parser.
//   Path: the byte that closes the frame is held in the input register, then
//   passes through the parser into the report register that drives out_.
//   Stall: when out_ holds a report that is not taken, the byte in the
//   input register waits, in_.ready drops while that register is full, and
//   nothing is lost or reordered.
//   Reset (rst_n low, synchronous): parser goes idle, both stages empty.
// ----------------------------------------------------------------------------
module gnss_binary_text_frame_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  gbtf_byte_if.sink           in_,
  gbtf_frame_if.source        out_
);

  // input stage
  logic              byte_vld_r;
  logic [7:0]        byte_r;

  // report stage
  logic              out_vld_r;
  gbtf_pkg::result_t out_res_r;

  logic              out_free;
  logic              step;
  logic              res_vld;
  gbtf_pkg::result_t res;

  // report register can load this cycle when empty or being drained
  assign out_free = !out_vld_r || out_.ready;
  // the parser advances only when its possible report has somewhere to go
  assign step     = byte_vld_r && out_free;
  assign in_.ready = !byte_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_.ready) begin
      byte_vld_r <= in_.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_.ready && in_.valid) begin
      byte_r <= in_.rx_byte;
    end
  end

  gbtf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (step),
    .rx_byte_i (byte_r),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_.valid         = out_vld_r;
  assign out_.frame_kind    = out_res_r.frame_kind;
  assign out_.frame_class   = out_res_r.frame_class;
  assign out_.frame_id      = out_res_r.frame_id;
  assign out_.frame_length  = out_res_r.frame_length;
  assign out_.checksum_ok   = out_res_r.checksum_ok;
  assign out_.star_seen     = out_res_r.star_seen;
  assign out_.header_ok     = out_res_r.header_ok;
  assign out_.talker_chars  = out_res_r.talker_chars;
  assign out_.type_chars    = out_res_r.type_chars;
  assign out_.header_length = out_res_r.header_length;

endmodule

/* hdl/gbtf_checker.sv */
// ----------------------------------------------------------------------------
// gbtf_checker
// Port-level checks on the frame parser's report channel and input ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbtf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_frame_kind,
  input logic [7:0]  out_frame_class,
  input logic [7:0]  out_frame_id,
  input logic [15:0] out_frame_length,
  input logic        out_checksum_ok,
  input logic        out_star_seen,
  input logic        out_header_ok,
  input logic [15:0] out_talker_chars,
  input logic [23:0] out_type_chars,
  input logic [5:0]  out_header_length
);

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "report valid right after reset")
  `ASSERT_CLK(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_frame_length) && $stable(out_talker_chars), "stalled report changed")
  `ASSERT_CLK(a_text_clean, out_valid && out_frame_kind |-> out_frame_class == 8'd0 && out_frame_id == 8'd0 && out_frame_length == 16'd0 && !out_checksum_ok, "text report carries binary fields")
  `ASSERT_CLK(a_hdr_rule, out_valid && (out_frame_kind ? !out_header_ok : 1'b1) |-> out_talker_chars == 16'd0 && out_type_chars == 24'd0 && (out_frame_kind || (!out_star_seen && out_header_length == 6'd0)), "header fields set without a valid header")
  `ASSERT_CLK(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty report stage")

endmodule

bind gnss_binary_text_frame_parser_top gbtf_checker u_gbtf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_.ready),
  .out_valid         (out_.valid),
  .out_ready         (out_.ready),
  .out_frame_kind    (out_.frame_kind),
  .out_frame_class   (out_.frame_class),
  .out_frame_id      (out_.frame_id),
  .out_frame_length  (out_.frame_length),
  .out_checksum_ok   (out_.checksum_ok),
  .out_star_seen     (out_.star_seen),
  .out_header_ok     (out_.header_ok),
  .out_talker_chars  (out_.talker_chars),
  .out_type_chars    (out_.type_chars),
  .out_header_length (out_.header_length)
);
